// ----- rtl/core/pkcs1_sha256_padding_checker_defines.svh -----
// Assertion macros for the PKCS#1 v1.5 SHA-256 padding checker.
// Used by the checker module only; no dependencies.
`ifndef PKCS1_SHA256_PADDING_CHECKER_DEFINES_SVH
`define PKCS1_SHA256_PADDING_CHECKER_DEFINES_SVH

// same-cycle implication
`define P1PAD_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define P1PAD_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/core/p1pad_pkg.sv -----
// Shared types, constants and the DigestInfo prefix table for the padding checker.
// No dependencies.
package p1pad_pkg;

   localparam int MAX_BLOCK_BYTES_DEF = 256;
   localparam int HASH_BYTES          = 32;
   localparam int PREFIX_BYTES        = 19;
   localparam int MOD_W               = 9;
   localparam int BYTE_W              = 8;
   localparam int HIDX_W              = 5;
   localparam int STATUS_W            = 4;

   localparam logic [MOD_W-1:0] MODULUS_RESET = 9'd256;

   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_BLOCK = 1'b1;

   localparam logic [BYTE_W-1:0] BYTE_ZERO = 8'h00;
   localparam logic [BYTE_W-1:0] BYTE_ONE  = 8'h01;
   localparam logic [BYTE_W-1:0] BYTE_FILL = 8'hFF;

   localparam logic [STATUS_W-1:0] ST_OK     = 4'd0;
   localparam logic [STATUS_W-1:0] ST_LENGTH = 4'd1;
   localparam logic [STATUS_W-1:0] ST_BYTE0  = 4'd2;
   localparam logic [STATUS_W-1:0] ST_BYTE1  = 4'd3;
   localparam logic [STATUS_W-1:0] ST_SEP    = 4'd4;
   localparam logic [STATUS_W-1:0] ST_ROOM   = 4'd5;
   localparam logic [STATUS_W-1:0] ST_PREFIX = 4'd6;
   localparam logic [STATUS_W-1:0] ST_HASH   = 4'd7;
   localparam logic [STATUS_W-1:0] ST_TRAIL  = 4'd8;

   typedef struct packed {
      logic              op;
      logic [HIDX_W-1:0] hash_index;
      logic [BYTE_W-1:0] data_byte;
      logic              last_byte;
   } req_type;

   typedef struct packed {
      logic                passed;
      logic [STATUS_W-1:0] status;
   } rsp_type;

   typedef struct packed {
      logic    valid;
      rsp_type data;
   } result_type;

   typedef enum logic [2:0] {
      PH_ZERO,
      PH_ONE,
      PH_FILL,
      PH_PREFIX,
      PH_HASH,
      PH_DONE
   } phase_type;

   // SHA-256 DigestInfo DER prefix
   function automatic logic [BYTE_W-1:0] prefix_byte(input logic [HIDX_W-1:0] idx);
      logic [BYTE_W-1:0] b;
      unique case (idx)
         5'd0:    b = 8'h30;
         5'd1:    b = 8'h31;
         5'd2:    b = 8'h30;
         5'd3:    b = 8'h0D;
         5'd4:    b = 8'h06;
         5'd5:    b = 8'h09;
         5'd6:    b = 8'h60;
         5'd7:    b = 8'h86;
         5'd8:    b = 8'h48;
         5'd9:    b = 8'h01;
         5'd10:   b = 8'h65;
         5'd11:   b = 8'h03;
         5'd12:   b = 8'h04;
         5'd13:   b = 8'h02;
         5'd14:   b = 8'h01;
         5'd15:   b = 8'h05;
         5'd16:   b = 8'h00;
         5'd17:   b = 8'h04;
         5'd18:   b = 8'h20;
         default: b = 8'h00;
      endcase
      return b;
   endfunction

endpackage

// ----- rtl/core/p1pad_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module p1pad_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/core/p1pad_parse.sv -----
// Block parser stage: one decoded byte per cycle against the EMSA-PKCS1-v1_5 layout.
// Depends on p1pad_pkg; the hash byte comes from the hash RAM in the cycle after the beat.
module p1pad_parse #(
   parameter int MAX_BLOCK_BYTES = p1pad_pkg::MAX_BLOCK_BYTES_DEF
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    in_valid,
   input  logic [p1pad_pkg::BYTE_W-1:0]            in_byte,
   input  logic                                    in_last,
   input  logic [p1pad_pkg::MOD_W-1:0]             modulus,
   input  logic [p1pad_pkg::BYTE_W-1:0]            hash_byte,
   output logic [p1pad_pkg::HIDX_W-1:0]            hash_addr,
   output p1pad_pkg::result_type                   result
);

   import p1pad_pkg::*;

   localparam int CNT_W = $clog2(MAX_BLOCK_BYTES + 2);
   localparam int LEN_W = (CNT_W > MOD_W) ? CNT_W : MOD_W;
   localparam int SUM_W = LEN_W + 1;
   localparam logic [HIDX_W-1:0] PREFIX_LAST = HIDX_W'(PREFIX_BYTES - 1);
   localparam logic [HIDX_W-1:0] HASH_LAST   = HIDX_W'(HASH_BYTES - 1);

   logic                s1_valid_ff, s1_valid_in;
   logic [BYTE_W-1:0]   s1_byte_ff;
   logic                s1_last_ff;
   phase_type           phase_ff, phase_in, take_phase;
   logic [CNT_W-1:0]    count_ff, count_in, count_inc;
   logic [HIDX_W-1:0]   offset_ff, offset_in, take_offset;
   logic [STATUS_W-1:0] error_ff, error_in, take_error;
   logic [STATUS_W-1:0] status;
   logic                room_ok, len_ok, working, closing;

   assign working = s1_valid_ff && (error_ff == ST_OK);
   assign closing = s1_valid_ff && s1_last_ff;

   assign count_inc = (count_ff <= CNT_W'(MAX_BLOCK_BYTES)) ? count_ff + CNT_W'(1) : count_ff;
   assign room_ok   = (SUM_W'(count_ff) + SUM_W'(PREFIX_BYTES + HASH_BYTES + 1))
                      <= SUM_W'(modulus);
   assign len_ok    = (modulus != '0) &&
                      (LEN_W'(modulus) <= LEN_W'(MAX_BLOCK_BYTES)) &&
                      (LEN_W'(count_inc) == LEN_W'(modulus));

   // next phase
   always_comb begin
      take_phase = phase_ff;
      if (working) begin
         unique case (phase_ff)
            PH_ZERO:   if (s1_byte_ff == BYTE_ZERO) take_phase = PH_ONE;
            PH_ONE:    if (s1_byte_ff == BYTE_ONE) take_phase = PH_FILL;
            PH_FILL:   if (s1_byte_ff == BYTE_ZERO && room_ok) take_phase = PH_PREFIX;
            PH_PREFIX: begin
               if (s1_byte_ff == prefix_byte(offset_ff) && offset_ff == PREFIX_LAST) begin
                  take_phase = PH_HASH;
               end
            end
            PH_HASH: begin
               if (s1_byte_ff == hash_byte && offset_ff == HASH_LAST) begin
                  take_phase = PH_DONE;
               end
            end
            PH_DONE:   take_phase = PH_DONE;
            default:   take_phase = phase_ff;
         endcase
      end
      phase_in = closing ? PH_ZERO : take_phase;
   end

   // error, offset and result
   always_comb begin
      take_error  = error_ff;
      take_offset = offset_ff;
      if (working) begin
         unique case (phase_ff)
            PH_ZERO: if (s1_byte_ff != BYTE_ZERO) take_error = ST_BYTE0;
            PH_ONE:  if (s1_byte_ff != BYTE_ONE) take_error = ST_BYTE1;
            PH_FILL: begin
               if (s1_byte_ff != BYTE_FILL) begin
                  if (s1_byte_ff != BYTE_ZERO) begin
                     take_error = ST_SEP;
                  end else if (!room_ok) begin
                     take_error = ST_ROOM;
                  end else begin
                     take_offset = '0;
                  end
               end
            end
            PH_PREFIX: begin
               if (s1_byte_ff != prefix_byte(offset_ff)) begin
                  take_error = ST_PREFIX;
               end else if (offset_ff == PREFIX_LAST) begin
                  take_offset = '0;
               end else begin
                  take_offset = offset_ff + HIDX_W'(1);
               end
            end
            PH_HASH: begin
               if (s1_byte_ff != hash_byte) begin
                  take_error = ST_HASH;
               end else if (offset_ff == HASH_LAST) begin
                  take_offset = '0;
               end else begin
                  take_offset = offset_ff + HIDX_W'(1);
               end
            end
            PH_DONE: take_error = ST_TRAIL;
            default: take_error = error_ff;
         endcase
      end

      if (!len_ok) begin
         status = ST_LENGTH;
      end else if (take_error != ST_OK) begin
         status = take_error;
      end else begin
         unique case (take_phase)
            PH_DONE: status = ST_OK;
            PH_ONE:  status = ST_BYTE1;
            PH_FILL: status = ST_SEP;
            PH_ZERO: status = ST_BYTE0;
            default: status = ST_ROOM;
         endcase
      end

      error_in  = closing ? ST_OK : take_error;
      offset_in = closing ? '0 : take_offset;
      if (!s1_valid_ff) begin
         count_in = count_ff;
      end else if (s1_last_ff) begin
         count_in = '0;
      end else begin
         count_in = count_inc;
      end

      result.valid       = closing;
      result.data.passed = (status == ST_OK);
      result.data.status = status;
   end

   assign s1_valid_in = in_valid;
   assign hash_addr   = offset_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         phase_ff    <= PH_ZERO;
         count_ff    <= '0;
         offset_ff   <= '0;
         error_ff    <= ST_OK;
      end else begin
         s1_valid_ff <= s1_valid_in;
         phase_ff    <= phase_in;
         count_ff    <= count_in;
         offset_ff   <= offset_in;
         error_ff    <= error_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_byte_ff <= in_byte;
      s1_last_ff <= in_last;
   end

endmodule

// ----- rtl/core/p1pad_outq.sv -----
// Two-entry result queue between the parser and the rsp channel.
// Depends on p1pad_pkg.
module p1pad_outq (
   input  logic                  clock,
   input  logic                  reset,
   input  p1pad_pkg::result_type push,
   input  logic                  out_stall,
   output logic                  out_valid,
   output p1pad_pkg::rsp_type    out_data,
   output logic                  almost_full
);

   import p1pad_pkg::*;

   localparam logic [1:0] FULL_LEVEL = 2'd2;

   rsp_type    slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] level_ff, level_in;
   logic       pop;

   assign out_valid   = (level_ff != 2'd0);
   assign out_data    = slot_ff[rd_ptr_ff];
   assign pop         = out_valid && !out_stall;
   assign level_in    = level_ff - 2'(pop) + 2'(push.valid);
   assign wr_ptr_in   = push.valid ? !wr_ptr_ff : wr_ptr_ff;
   assign rd_ptr_in   = pop ? !rd_ptr_ff : rd_ptr_ff;
   // a beat taken now may bring a result in the next cycle
   assign almost_full = (level_in == FULL_LEVEL);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         level_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.valid) begin
         slot_ff[wr_ptr_ff] <= push.data;
      end
   end

endmodule

// ----- rtl/core/pkcs1_sha256_padding_checker.sv -----
// PKCS#1 v1.5 SHA-256 signature padding checker, top level.
// Depends on p1pad_pkg, p1pad_ram, p1pad_parse and p1pad_outq.
//
// Usage:
//   csr_write_enable/csr_write_data set modulus_bytes, the expected block
//   length (reset value 256). Write it only while the block is idle.
//   req beats with op = 0 load one expected hash byte at hash_index.
//   req beats with op = 1 stream the decoded block, first byte first;
//   last_byte marks its final byte. Loads may be mixed in at any time.
//   One rsp beat (passed, status) follows each block.
// Timing:
//   One req beat per cycle while req_stall is low. A block byte reads the hash
//   RAM as it is taken and is compared in the next cycle; the last byte passes
//   the parser stage register and then the result queue, which drives rsp_valid.
// Reset:
//   Clears the parser and the result queue; modulus_bytes returns to 256.
//   The hash RAM is not cleared; load all 32 bytes before the first block.
// Stall:
//   Results wait in a two-entry queue while rsp_stall is high; req_stall
//   rises once a further result could not be held.
module pkcs1_sha256_padding_checker #(
   parameter int MAX_BLOCK_BYTES = p1pad_pkg::MAX_BLOCK_BYTES_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  p1pad_pkg::req_type            req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output p1pad_pkg::rsp_type            rsp_data,
   input  logic                          csr_write_enable,
   input  logic [p1pad_pkg::MOD_W-1:0]   csr_write_data
);

   import p1pad_pkg::*;

   logic [MOD_W-1:0]  modulus_ff;
   logic              accept, load_beat, block_beat;
   logic [HIDX_W-1:0] hash_addr;
   logic [BYTE_W-1:0] hash_byte;
   result_type        result;
   logic              almost_full;

   assign req_stall  = almost_full;
   assign accept     = req_valid && !req_stall;
   assign load_beat  = accept && (req_data.op == OP_LOAD);
   assign block_beat = accept && (req_data.op == OP_BLOCK);

   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff <= MODULUS_RESET;
      end else if (csr_write_enable) begin
         modulus_ff <= csr_write_data;
      end
   end

   p1pad_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (HASH_BYTES)
   ) u_hash_ram (
      .clock   (clock),
      .wr_en   (load_beat),
      .wr_addr (req_data.hash_index),
      .wr_data (req_data.data_byte),
      .rd_en   (block_beat),
      .rd_addr (hash_addr),
      .rd_data (hash_byte)
   );

   p1pad_parse #(
      .MAX_BLOCK_BYTES (MAX_BLOCK_BYTES)
   ) u_parse (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (block_beat),
      .in_byte   (req_data.data_byte),
      .in_last   (req_data.last_byte),
      .modulus   (modulus_ff),
      .hash_byte (hash_byte),
      .hash_addr (hash_addr),
      .result    (result)
   );

   p1pad_outq u_outq (
      .clock       (clock),
      .reset       (reset),
      .push        (result),
      .out_stall   (rsp_stall),
      .out_valid   (rsp_valid),
      .out_data    (rsp_data),
      .almost_full (almost_full)
   );

endmodule

// ----- rtl/core/p1pad_checker.sv -----
// Port-level checks for the padding checker, bound to the top level.
// Depends on p1pad_pkg and pkcs1_sha256_padding_checker_defines.svh.
`include "pkcs1_sha256_padding_checker_defines.svh"

module p1pad_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_stall,
   input p1pad_pkg::req_type          req_data,
   input logic                        rsp_valid,
   input logic                        rsp_stall,
   input p1pad_pkg::rsp_type          rsp_data
);

   import p1pad_pkg::*;

   logic last_block_beat;

   assign last_block_beat = req_valid && !req_stall && (req_data.op == OP_BLOCK) &&
                            req_data.last_byte;

   `P1PAD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_data), "stalled rsp beat changed")

   `P1PAD_ASSERT_NOW(a_pass_status, clock, reset, rsp_valid,
      rsp_data.passed == (rsp_data.status == ST_OK), "passed disagrees with status")

   `P1PAD_ASSERT_NOW(a_status_range, clock, reset, rsp_valid,
      rsp_data.status <= ST_TRAIL, "status code out of range")

   `P1PAD_ASSERT_NOW(a_rsp_cause, clock, reset, $rose(rsp_valid),
      $past(last_block_beat, 2), "rsp beat without a last block byte")

endmodule

bind pkcs1_sha256_padding_checker p1pad_checker u_p1pad_checker (.*);

// ----- test/pkcs1_sha256_padding_checker_tb.sv -----
// Self-checking bench for the PKCS#1 v1.5 SHA-256 padding checker: a clocked
// driver and monitor around the block and an in-bench padding predictor.
// Depends on p1pad_pkg and the pkcs1_sha256_padding_checker RTL.
module pkcs1_sha256_padding_checker_tb;
   import p1pad_pkg::*;

   localparam int BLOCK_LIMIT    = MAX_BLOCK_BYTES_DEF;
   localparam int MIN_FRAME      = 3 + PREFIX_BYTES + HASH_BYTES;
   localparam int RANDOM_BEATS   = 1400;
   localparam int MIN_FRAMES     = 48;
   localparam int LONG_HOLD      = 400;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int DRAIN_CYCLES   = 8;
   localparam int REPORT_CAP     = 50;

   typedef logic [BYTE_W-1:0] byte_q_t [$];

   logic                clock            = 1'b0;
   logic                reset            = 1'b1;
   logic                req_valid        = 1'b0;
   logic                req_stall;
   req_type             req_data         = '0;
   logic                rsp_valid;
   logic                rsp_stall        = 1'b0;
   rsp_type             rsp_data;
   logic                csr_write_enable = 1'b0;
   logic [MOD_W-1:0]    csr_write_data   = '0;

   logic [BYTE_W-1:0] digest_info [PREFIX_BYTES] = '{
      8'h30, 8'h31, 8'h30, 8'h0D, 8'h06, 8'h09, 8'h60, 8'h86, 8'h48, 8'h01,
      8'h65, 8'h03, 8'h04, 8'h02, 8'h01, 8'h05, 8'h00, 8'h04, 8'h20
   };

   // predictor state
   logic [MOD_W-1:0]    modulus_model = MODULUS_RESET;
   logic [BYTE_W-1:0]   hash_model [HASH_BYTES];
   phase_type           phase_model   = PH_ZERO;
   int                  count_model   = 0;
   int                  offset_model  = 0;
   logic [STATUS_W-1:0] error_model   = ST_OK;
   rsp_type             verdict_queue [$];

   // stimulus state
   req_type             byte_backlog [$];
   logic [BYTE_W-1:0]   stim_hash [HASH_BYTES];
   int                  beats_queued    = 0;
   int                  beats_accepted  = 0;
   int                  frames_queued   = 0;
   logic                pressure_phase  = 1'b0;

   int                  send_gap        = 0;
   int                  send_quiet      = 0;
   int                  hold_left       = 0;
   int                  recv_quiet      = 0;
   bit                  long_hold_done  = 1'b0;
   rsp_type             oldest_verdict;
   int                  verdicts_checked = 0;
   int                  verdicts_passed  = 0;
   logic [8:0]          status_seen      = '0;
   int                  mismatch_count   = 0;
   int                  stuck_cycles     = 0;

   pkcs1_sha256_padding_checker DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   function automatic int draw_wait(inout int quiet_run);
      if (quiet_run > 0) begin
         quiet_run--;
         return 0;
      end
      if ($urandom_range(0, 39) == 0) begin
         quiet_run = $urandom_range(16, 64);
         return 0;
      end
      return ($urandom_range(0, 1) == 1) ? 0 : $urandom_range(0, 16);
   endfunction

   task automatic check_padding_byte(input req_type beat);
      int                  idx;
      bit                  len_ok;
      logic [STATUS_W-1:0] status;
      rsp_type             verdict;
      if (beat.op == OP_LOAD) begin
         hash_model[beat.hash_index] = beat.data_byte;
         return;
      end
      idx = count_model;
      if (count_model <= BLOCK_LIMIT) count_model++;
      if (error_model == ST_OK) begin
         case (phase_model)
            PH_ZERO: begin
               if (beat.data_byte != BYTE_ZERO) error_model = ST_BYTE0;
               else phase_model = PH_ONE;
            end
            PH_ONE: begin
               if (beat.data_byte != BYTE_ONE) error_model = ST_BYTE1;
               else phase_model = PH_FILL;
            end
            PH_FILL: begin
               if (beat.data_byte == BYTE_FILL) begin
               end else if (beat.data_byte != BYTE_ZERO) begin
                  error_model = ST_SEP;
               end else if (idx + 1 + PREFIX_BYTES + HASH_BYTES > int'(modulus_model)) begin
                  error_model = ST_ROOM;
               end else begin
                  phase_model  = PH_PREFIX;
                  offset_model = 0;
               end
            end
            PH_PREFIX: begin
               if (offset_model >= PREFIX_BYTES ||
                   beat.data_byte != digest_info[offset_model]) begin
                  error_model = ST_PREFIX;
               end else begin
                  offset_model++;
                  if (offset_model == PREFIX_BYTES) begin
                     phase_model  = PH_HASH;
                     offset_model = 0;
                  end
               end
            end
            PH_HASH: begin
               if (offset_model >= HASH_BYTES ||
                   beat.data_byte != hash_model[offset_model]) begin
                  error_model = ST_HASH;
               end else begin
                  offset_model++;
                  if (offset_model == HASH_BYTES) begin
                     phase_model  = PH_DONE;
                     offset_model = 0;
                  end
               end
            end
            default: error_model = ST_TRAIL;
         endcase
      end
      if (!beat.last_byte) return;
      len_ok = modulus_model >= 1 && int'(modulus_model) <= BLOCK_LIMIT &&
               count_model == int'(modulus_model);
      if (!len_ok) status = ST_LENGTH;
      else if (error_model != ST_OK) status = error_model;
      else if (phase_model == PH_DONE) status = ST_OK;
      else if (phase_model == PH_ONE) status = ST_BYTE1;
      else if (phase_model == PH_FILL) status = ST_SEP;
      else if (phase_model == PH_ZERO) status = ST_BYTE0;
      else status = ST_ROOM;
      verdict.passed = (status == ST_OK);
      verdict.status = status;
      verdict_queue.push_back(verdict);
      phase_model  = PH_ZERO;
      count_model  = 0;
      offset_model = 0;
      error_model  = ST_OK;
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (csr_write_enable) modulus_model = csr_write_data;
         if (req_valid && !req_stall) begin
            check_padding_byte(req_data);
            beats_accepted++;
         end
         if (!req_valid || !req_stall) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (byte_backlog.size() > 0) begin
               req_data  <= byte_backlog.pop_front();
               req_valid <= 1'b1;
               send_gap = draw_wait(send_quiet);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (verdict_queue.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_CAP)
                  $display("%0t: unexpected verdict, expected none, actual passed=%0b status=%0d",
                           $time, rsp_data.passed, rsp_data.status);
            end else begin
               oldest_verdict = verdict_queue.pop_front();
               if (rsp_data.passed !== oldest_verdict.passed) begin
                  mismatch_count++;
                  if (mismatch_count <= REPORT_CAP)
                     $display("%0t: passed mismatch, expected %0b, actual %0b",
                              $time, oldest_verdict.passed, rsp_data.passed);
               end
               if (rsp_data.status !== oldest_verdict.status) begin
                  mismatch_count++;
                  if (mismatch_count <= REPORT_CAP)
                     $display("%0t: status mismatch, expected %0d, actual %0d",
                              $time, oldest_verdict.status, rsp_data.status);
               end
               verdicts_checked++;
               if (oldest_verdict.passed) verdicts_passed++;
               status_seen[oldest_verdict.status] = 1'b1;
            end
            hold_left = draw_wait(recv_quiet);
         end else if (hold_left > 0) begin
            hold_left--;
         end
         // long hold-off so that results back up into the request side
         if (pressure_phase && !long_hold_done) begin
            hold_left      = LONG_HOLD;
            long_hold_done = 1'b1;
         end
         rsp_stall <= (hold_left > 0);
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         stuck_cycles <= 0;
      end else if (stuck_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no beat moved for %0d cycles", $time, stuck_cycles);
         $display("pkcs1_sha256_padding_checker regression: fail");
         $finish;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
      end
   end

   task automatic queue_beat(input logic op, input logic [HIDX_W-1:0] idx,
                             input logic [BYTE_W-1:0] data, input logic last);
      req_type beat;
      beat.op         = op;
      beat.hash_index = idx;
      beat.data_byte  = data;
      beat.last_byte  = last;
      if (op == OP_LOAD) stim_hash[idx] = data;
      if (op == OP_BLOCK && last) frames_queued++;
      byte_backlog.push_back(beat);
      beats_queued++;
   endtask

   task automatic load_hash_table();
      for (int i = 0; i < HASH_BYTES; i++)
         queue_beat(OP_LOAD, HIDX_W'(i), BYTE_W'($urandom_range(0, 255)),
                    1'($urandom_range(0, 1)));
   endtask

   task automatic queue_frame(input byte_q_t frame);
      logic [HIDX_W-1:0] slot;
      for (int i = 0; i < frame.size(); i++) begin
         // stray hash load mid-frame, usually rewriting the same value
         if ($urandom_range(0, 31) == 0) begin
            slot = HIDX_W'($urandom_range(0, 31));
            queue_beat(OP_LOAD, slot,
                       ($urandom_range(0, 4) == 0) ? BYTE_W'($urandom_range(0, 255))
                                                   : stim_hash[slot],
                       1'($urandom_range(0, 1)));
         end
         queue_beat(OP_BLOCK, HIDX_W'($urandom_range(0, 31)), frame[i],
                    i == frame.size() - 1);
      end
   endtask

   task automatic build_frame(input int len, input int trail, output byte_q_t frame);
      frame = {};
      frame.push_back(BYTE_ZERO);
      frame.push_back(BYTE_ONE);
      repeat (len - MIN_FRAME - trail) frame.push_back(BYTE_FILL);
      frame.push_back(BYTE_ZERO);
      for (int i = 0; i < PREFIX_BYTES; i++) frame.push_back(digest_info[i]);
      for (int i = 0; i < HASH_BYTES; i++) frame.push_back(stim_hash[i]);
      repeat (trail) frame.push_back(BYTE_W'($urandom_range(0, 255)));
   endtask

   task automatic queue_random_frame(input int modulus, input bit noise_only);
      byte_q_t frame;
      int      base;
      int      kind;
      int      pos;
      int      n;
      base = (modulus >= MIN_FRAME && modulus <= BLOCK_LIMIT) ? modulus
             : $urandom_range(MIN_FRAME, MIN_FRAME + 10);
      kind = noise_only ? 99 : $urandom_range(0, 99);
      frame = {};
      if (kind >= 90) begin
         n = ($urandom_range(0, 1) == 1 && modulus >= 1 && modulus <= 16) ? modulus
             : $urandom_range(1, 6);
         for (int i = 0; i < n; i++) begin
            if (i == 0)
               frame.push_back(($urandom_range(0, 3) != 0) ? BYTE_ZERO
                               : BYTE_W'($urandom_range(0, 255)));
            else if (i == 1)
               frame.push_back(($urandom_range(0, 3) != 0) ? BYTE_ONE
                               : BYTE_W'($urandom_range(0, 255)));
            else
               case ($urandom_range(0, 3))
                  0, 1:    frame.push_back(BYTE_FILL);
                  2:       frame.push_back(BYTE_ZERO);
                  default: frame.push_back(BYTE_W'($urandom_range(0, 255)));
               endcase
         end
      end else begin
         n = (kind >= 50 && kind < 60 && base > MIN_FRAME)
             ? $urandom_range(1, (base - MIN_FRAME > 8) ? 8 : base - MIN_FRAME) : 0;
         build_frame(base, n, frame);
         if (kind >= 60 && kind < 70) begin
            pos = $urandom_range(0, frame.size() - 1);
            frame[pos] = frame[pos] ^ BYTE_W'($urandom_range(1, 255));
         end else if (kind >= 70 && kind < 76) begin
            pos = base - HASH_BYTES - PREFIX_BYTES + $urandom_range(0, PREFIX_BYTES - 1);
            frame[pos] = frame[pos] ^ BYTE_W'($urandom_range(1, 255));
         end else if (kind >= 76 && kind < 84) begin
            pos = base - 1 - $urandom_range(0, HASH_BYTES - 1);
            frame[pos] = frame[pos] ^ BYTE_W'($urandom_range(1, 255));
         end else if (kind >= 84) begin
            if ($urandom_range(0, 1) == 1)
               repeat ($urandom_range(1, 3)) void'(frame.pop_back());
            else
               repeat ($urandom_range(1, 3)) frame.push_back(BYTE_W'($urandom_range(0, 255)));
         end
      end
      queue_frame(frame);
   endtask

   task automatic wait_for_idle();
      while (beats_accepted != beats_queued || verdict_queue.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_modulus(input int value);
      wait_for_idle();
      csr_write_enable <= 1'b1;
      csr_write_data   <= MOD_W'(value);
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   initial begin
      byte_q_t frame;
      int      phase_no;
      int      start_beats;
      int      modulus;
      int      pick;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      load_hash_table();

      // short blocks that end in every early state
      set_modulus(1);
      queue_beat(OP_BLOCK, '0, BYTE_ZERO, 1'b1);
      queue_beat(OP_BLOCK, '1, BYTE_FILL, 1'b1);
      queue_beat(OP_LOAD, '1, stim_hash[HASH_BYTES - 1], 1'b1);
      set_modulus(2);
      queue_beat(OP_BLOCK, '0, BYTE_ZERO, 1'b0);
      queue_beat(OP_BLOCK, '1, BYTE_ONE, 1'b1);
      queue_beat(OP_BLOCK, '0, BYTE_ZERO, 1'b0);
      queue_beat(OP_BLOCK, '1, BYTE_ZERO, 1'b1);
      set_modulus(3);
      queue_beat(OP_BLOCK, '0, BYTE_ZERO, 1'b0);
      queue_beat(OP_BLOCK, '0, BYTE_ONE, 1'b0);
      queue_beat(OP_BLOCK, '1, BYTE_ZERO, 1'b1);
      queue_beat(OP_BLOCK, '0, BYTE_ZERO, 1'b0);
      queue_beat(OP_BLOCK, '0, BYTE_ONE, 1'b0);
      queue_beat(OP_BLOCK, '1, BYTE_FILL, 1'b1);
      set_modulus(0);
      queue_beat(OP_BLOCK, '0, BYTE_ZERO, 1'b1);
      set_modulus(511);
      queue_beat(OP_BLOCK, '0, BYTE_ZERO, 1'b0);
      queue_beat(OP_BLOCK, '1, BYTE_ONE, 1'b1);

      phase_no    = 0;
      start_beats = beats_queued;
      while (beats_queued - start_beats < RANDOM_BEATS || frames_queued < MIN_FRAMES) begin
         case (phase_no)
            0:       modulus = BLOCK_LIMIT;
            1:       modulus = MIN_FRAME;
            2:       modulus = 4;
            3:       modulus = 300;
            default: begin
               pick = $urandom_range(0, 19);
               if (pick < 14) modulus = $urandom_range(MIN_FRAME, MIN_FRAME + 40);
               else if (pick < 16) modulus = $urandom_range(BLOCK_LIMIT - 1, BLOCK_LIMIT);
               else if (pick < 18) modulus = $urandom_range(1, MIN_FRAME - 1);
               else if (pick == 18) modulus = 0;
               else modulus = $urandom_range(BLOCK_LIMIT + 1, 511);
            end
         endcase
         set_modulus(modulus);
         if ($urandom_range(0, 3) == 0) load_hash_table();
         if (phase_no == 2) begin
            pressure_phase <= 1'b1;
            repeat (40) queue_random_frame(modulus, 1'b1);
         end else if (phase_no == 3) begin
            // overlong block so that the byte counter saturates
            build_frame(BLOCK_LIMIT, 0, frame);
            repeat (modulus - BLOCK_LIMIT) frame.push_back(BYTE_W'($urandom_range(0, 255)));
            queue_frame(frame);
            repeat (2) queue_random_frame(modulus, 1'b0);
         end else begin
            repeat ((modulus > 128) ? $urandom_range(1, 2) : $urandom_range(3, 8))
               queue_random_frame(modulus, 1'b0);
         end
         phase_no++;
      end

      wait_for_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Covered %0d beats over %0d length settings; %0d verdicts checked, %0d passing.",
               beats_accepted, phase_no + 5, verdicts_checked, verdicts_passed);
      $display("Status codes seen (bit per code, 8 down to 0): %b", status_seen);
      if (mismatch_count == 0)
         $display("pkcs1_sha256_padding_checker regression: pass");
      else
         $display("pkcs1_sha256_padding_checker regression: fail");
      $finish;
   end

endmodule
